@@ hdl/jsu_pkg.sv @@
// Shared types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

	localparam int DATA_W = 8;
	localparam int KIND_W = 2;
	localparam int ERR_W  = 3;
	localparam int MAX_RES = 3;
	localparam int CNT_W  = 2;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

	localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NO_QUOTE = 3'd1;
	localparam logic [ERR_W-1:0] ERR_UNTERM   = 3'd2;
	localparam logic [ERR_W-1:0] ERR_BAD_ESC  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_BAD_HEX  = 3'd4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [7:0] UTF8_CONT  = 8'h80;
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_MASK6 = 8'h3F;

	// one decoded group of results caused by a single input byte
	typedef struct packed {
		logic [CNT_W-1:0]                count;
		logic [MAX_RES-1:0][DATA_W-1:0] bytes;
		logic [KIND_W-1:0]              kind;
		logic [ERR_W-1:0]               err;
	} dec_res_t;

	// bit 4 flags a valid digit, bits 3:0 give its value
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

endpackage

@@ hdl/json_string_unescape.sv @@
// Requests go through the input stage register and then the result register.
// Throughput: one byte per cycle while m_tready is high; a u escape ending in a
// 2 or 3 byte UTF-8 form holds the input stage while the result register drains.
// Reset (arst_n, async, active low) clears the stage valids and returns the
// decoder to idle, awaiting the opening quote.
module json_string_unescape (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] end_of_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [4:0]  m_tuser,   // [1:0] result_kind, [4:2] error_code
	output logic        m_tlast    // last_of_run
);
	import jsu_pkg::*;

	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              eod_s1;
	logic              advance;
	logic              can_load;
	dec_res_t          res;
	logic [KIND_W-1:0] kind;
	logic [ERR_W-1:0]  err;

	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			eod_s1  <= s_tuser[0];
		end
	end

	jsu_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (advance),
		.data_byte   (data_s1),
		.end_of_data (eod_s1),
		.res         (res)
	);

	jsu_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.res         (res),
		.can_load    (can_load),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_byte    (m_tdata),
		.result_kind (kind),
		.error_code  (err),
		.last_of_run (m_tlast)
	);

	assign m_tuser = {err, kind};

`ifndef NO_ASSERTIONS
	// end markers and errors are always single results
	a_single_nonbyte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind != KIND_BYTE |-> m_tlast)
		else $error("end or error result not marked last");

	a_err_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == KIND_ERR |-> err != ERR_NONE)
		else $error("error result without a code");

	a_byte_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind != KIND_ERR |-> err == ERR_NONE)
		else $error("code set on a non-error result");

	// a stalled input stage only drops once the result register frees up
	a_stall_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s_tready |=> valid_s1)
		else $error("input stage lost a request while stalled");
`endif

endmodule

@@ hdl/jsu_decode.sv @@
// Decoder state registers and the per-byte unescape logic.
module jsu_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        commit,
	input  logic [jsu_pkg::DATA_W-1:0]  data_byte,
	input  logic                        end_of_data,
	output jsu_pkg::dec_res_t           res
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_d;
	logic [1:0]  digits_q, digits_d;
	logic [15:0] cp_q, cp_d;
	logic [4:0]  hv;
	logic [15:0] cp_new;

	assign hv     = hex_value(data_byte);
	assign cp_new = {cp_q[11:0], hv[3:0]};

	always_comb begin
		mode_d   = mode_q;
		digits_d = digits_q;
		cp_d     = cp_q;
		res       = '0;
		res.kind  = KIND_BYTE;
		res.err   = ERR_NONE;
		case (mode_q)
			MODE_IDLE: begin
				if (end_of_data || data_byte != CH_QUOTE) begin
					res.count = 2'd1;
					res.kind  = KIND_ERR;
					res.err   = ERR_NO_QUOTE;
				end else begin
					mode_d = MODE_STR;
				end
			end
			MODE_STR: begin
				if (end_of_data) begin
					res.count = 2'd1;
					res.kind  = KIND_ERR;
					res.err   = ERR_UNTERM;
					mode_d    = MODE_IDLE;
				end else if (data_byte == CH_QUOTE) begin
					res.count = 2'd1;
					res.kind  = KIND_END;
					mode_d    = MODE_IDLE;
				end else if (data_byte == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					res.count    = 2'd1;
					res.bytes[0] = data_byte;
				end
			end
			MODE_ESC: begin
				res.count = 2'd1;
				mode_d    = MODE_STR;
				if (end_of_data) begin
					res.kind = KIND_ERR;
					res.err  = ERR_BAD_ESC;
					mode_d   = MODE_IDLE;
				end else begin
					case (data_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = data_byte;
						8'h62: res.bytes[0] = 8'h08;
						8'h66: res.bytes[0] = 8'h0C;
						8'h6E: res.bytes[0] = 8'h0A;
						8'h72: res.bytes[0] = 8'h0D;
						8'h74: res.bytes[0] = 8'h09;
						8'h75: begin
							res.count = 2'd0;
							mode_d    = MODE_HEX;
							digits_d  = 2'd0;
							cp_d      = 16'd0;
						end
						default: begin
							res.kind = KIND_ERR;
							res.err  = ERR_BAD_ESC;
							mode_d   = MODE_IDLE;
						end
					endcase
				end
			end
			default: begin
				if (end_of_data || !hv[4]) begin
					res.count = 2'd1;
					res.kind  = KIND_ERR;
					res.err   = ERR_BAD_HEX;
					mode_d    = MODE_IDLE;
					digits_d  = 2'd0;
					cp_d      = 16'd0;
				end else if (digits_q == 2'd3) begin
					mode_d   = MODE_STR;
					digits_d = 2'd0;
					cp_d     = 16'd0;
					if (cp_new[15:7] == '0) begin
						res.count    = 2'd1;
						res.bytes[0] = cp_new[7:0];
					end else if (cp_new[15:11] == '0) begin
						res.count    = 2'd2;
						res.bytes[0] = UTF8_LEAD2 | {3'd0, cp_new[10:6]};
						res.bytes[1] = UTF8_CONT | (cp_new[7:0] & UTF8_MASK6);
					end else begin
						res.count    = 2'd3;
						res.bytes[0] = UTF8_LEAD3 | {4'd0, cp_new[15:12]};
						res.bytes[1] = UTF8_CONT | (cp_new[13:6] & UTF8_MASK6);
						res.bytes[2] = UTF8_CONT | (cp_new[7:0] & UTF8_MASK6);
					end
				end else begin
					digits_d = digits_q + 2'd1;
					cp_d     = cp_new;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			digits_q <= 2'd0;
			cp_q     <= 16'd0;
		end else if (commit) begin
			mode_q   <= mode_d;
			digits_q <= digits_d;
			cp_q     <= cp_d;
		end
	end

endmodule

@@ hdl/jsu_out_buf.sv @@
// Result register that hands out one decoded group a result at a time.
module jsu_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  jsu_pkg::dec_res_t           res,
	output logic                        can_load,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [jsu_pkg::DATA_W-1:0]  out_byte,
	output logic [jsu_pkg::KIND_W-1:0]  result_kind,
	output logic [jsu_pkg::ERR_W-1:0]   error_code,
	output logic                        last_of_run
);
	import jsu_pkg::*;

	logic [CNT_W-1:0]                total_q;
	logic [CNT_W-1:0]                idx_q;
	logic [MAX_RES-1:0][DATA_W-1:0] bytes_q;
	logic [KIND_W-1:0]              kind_q;
	logic [ERR_W-1:0]               err_q;
	logic                           pop;

	assign m_tvalid    = (total_q != '0);
	assign last_of_run = (idx_q == total_q - 2'd1);
	assign pop         = m_tvalid && m_tready;
	assign can_load    = !m_tvalid || (m_tready && last_of_run);
	assign out_byte    = bytes_q[idx_q];
	assign result_kind = kind_q;
	assign error_code  = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			idx_q   <= '0;
		end else if (load && can_load) begin
			total_q <= res.count;
			idx_q   <= '0;
		end else if (pop) begin
			if (last_of_run)
				total_q <= '0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			bytes_q <= res.bytes;
			kind_q  <= res.kind;
			err_q   <= res.err;
		end
	end

endmodule
